/* hw/rtl/csw_pkg.sv */
// ----------------------------------------------------------------------------
// csw_pkg
// Shared types and constants for the call statistics window accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
package csw_pkg;
   localparam int Gateways     = 64;
   localparam int Window       = 8;
   localparam int Transactions = 256;
   localparam int GwW   = 6;
   localparam int WinW  = 3;
   localparam int SlotW = 8;

   localparam logic [1:0] CMD_INVITE = 2'd0;
   localparam logic [1:0] CMD_REPLY  = 2'd1;
   localparam logic [1:0] CMD_END    = 2'd2;
   localparam logic [1:0] CMD_TICK   = 2'd3;

   localparam logic [9:0] CODE_RINGING  = 10'd180;
   localparam logic [9:0] CODE_PROGRESS = 10'd183;
   localparam logic [9:0] CODE_OK       = 10'd200;
   localparam logic [9:0] CODE_SERVER   = 10'd500;
   localparam logic [9:0] CODE_TIMEOUT  = 10'd408;

   localparam logic [31:0] Max32 = 32'hFFFF_FFFF;
   localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;

   // one interval record: six counts and three sums
   typedef struct packed {
      logic [31:0] replies;
      logic [31:0] answered;
      logic [31:0] completed;
      logic [31:0] pdd_count;
      logic [31:0] setup_count;
      logic [31:0] duration_count;
      logic [47:0] pdd_total;
      logic [47:0] setup_total;
      logic [47:0] duration_total;
   } stats_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  txn_slot;
      logic        first_branch;
      logic [5:0]  gateway;
      logic [9:0]  response_code;
      logic        net_reply;
      logic [31:0] elapsed_ms;
      logic [31:0] duration_s;
   } req_type;

   typedef struct packed {
      logic [5:0]  gateway_out;
      logic [31:0] replies;
      logic [31:0] answered;
      logic [31:0] completed;
      logic [31:0] pdd_count;
      logic [47:0] pdd_total_ms;
      logic [31:0] setup_count;
      logic [47:0] setup_total_ms;
      logic [31:0] duration_count;
      logic [47:0] duration_total_s;
   } rsp_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] a, input logic en);
      sat_inc = (en && a != Max32) ? a + 32'd1 : a;
   endfunction

   function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [31:0] b,
                                           input logic en);
      logic [48:0] t;
      t = {1'b0, a} + {17'd0, b};
      if (!en) sat_add = a;
      else sat_add = (t > {1'b0, Max48}) ? Max48 : t[47:0];
   endfunction
endpackage
`default_nettype wire

/* hw/rtl/csw_req_if.sv */
// ----------------------------------------------------------------------------
// csw_req_if / csw_rsp_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
`default_nettype none
interface csw_req_if import csw_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface csw_rsp_if import csw_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/csw_ring_sum.sv */
// ----------------------------------------------------------------------------
// csw_ring_sum
// Accumulates ring entries one per cycle into saturated window sums.
// ----------------------------------------------------------------------------
`default_nettype none
module csw_ring_sum import csw_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      clear,
   input  wire logic      add,
   input  wire stats_type entry,
   output stats_type      sum
);
   stats_type acc_ff, acc_in;

   function automatic logic [31:0] cadd(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] t;
      t = {1'b0, a} + {1'b0, b};
      cadd = t[32] ? Max32 : t[31:0];
   endfunction

   function automatic logic [47:0] sadd(input logic [47:0] a, input logic [47:0] b);
      logic [48:0] t;
      t = {1'b0, a} + {1'b0, b};
      sadd = t[48] ? Max48 : t[47:0];
   endfunction

   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (add) begin
         acc_in.replies        = cadd(acc_ff.replies, entry.replies);
         acc_in.answered       = cadd(acc_ff.answered, entry.answered);
         acc_in.completed      = cadd(acc_ff.completed, entry.completed);
         acc_in.pdd_count      = cadd(acc_ff.pdd_count, entry.pdd_count);
         acc_in.setup_count    = cadd(acc_ff.setup_count, entry.setup_count);
         acc_in.duration_count = cadd(acc_ff.duration_count, entry.duration_count);
         acc_in.pdd_total      = sadd(acc_ff.pdd_total, entry.pdd_total);
         acc_in.setup_total    = sadd(acc_ff.setup_total, entry.setup_total);
         acc_in.duration_total = sadd(acc_ff.duration_total, entry.duration_total);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) acc_ff <= '0;
      else acc_ff <= acc_in;
   end

   assign sum = acc_ff;
endmodule
`default_nettype wire

/* hw/rtl/call_stats_window_accumulator_top.sv */
// ----------------------------------------------------------------------------
// call_stats_window_accumulator_top
// Per-gateway call statistics over a sliding window of intervals.
// ----------------------------------------------------------------------------
// Items are handled one at a time. Invite, reply and call-end items pass
// through accept, read and modify/write steps of the transaction and
// current-interval memories. A tick writes the current interval into the
// ring memory, then reads the ring entries back one per cycle and sums
// them, and loads the sums into the output register. After reset a
// clearing pass over all Gateways * Window ring entries zeroes the ring
// memory, the transaction delay flags and the ring pointers; no item is
// accepted meanwhile. The result waits in an output register; a following
// tick holds in its last cycle until the previous result has been taken.
`default_nettype none
module call_stats_window_accumulator_top import csw_pkg::*; (
   input wire logic  clock,
   input wire logic  reset,
   csw_req_if.sink   req,
   csw_rsp_if.source rsp
);
   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_MOD   = 6'b001000,
      ST_SUM   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   req_type   item_ff, item_in;

   // memories
   logic [GwW-1:0] txn_gw_mem [Transactions];
   logic           txn_done_mem [Transactions];
   stats_type      cur_mem [Gateways];
   stats_type      ring_mem [Gateways*Window];
   logic [WinW-1:0] ptr_mem [Gateways];
   logic           cur_valid_ff [Gateways];

   logic [GwW-1:0] gw_rd_ff;
   logic           done_rd_ff;
   logic [WinW-1:0] ptr_rd_ff;
   stats_type      cur_rd_ff;
   stats_type      ring_rd_ff;
   logic [GwW+WinW-1:0] clr_ff, clr_in;
   logic [WinW:0]  cnt_ff, cnt_in;
   logic           ring_rd_en, sum_add_ff;
   logic [GwW+WinW-1:0] ring_raddr;
   stats_type      cur_eff, cur_new, sum;
   rsp_type        out_ff;
   logic           out_valid_ff;
   logic           gw_sel;
   logic [GwW-1:0] g;
   logic           done_bit;
   logic [9:0]     code;
   logic           is_ring, is_ok, mid;

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = out_valid_ff;
   assign rsp.data  = out_ff;

   // gateway selection: reply uses the slot's stored gateway
   assign gw_sel = (item_ff.cmd == CMD_REPLY);
   assign g = gw_sel ? gw_rd_ff : item_ff.gateway;
   assign cur_eff = cur_valid_ff[g] ? cur_rd_ff : '0;
   assign done_bit = done_rd_ff;
   assign code = item_ff.response_code;
   assign is_ring = (code == CODE_RINGING) || (code == CODE_PROGRESS);
   assign is_ok = (code == CODE_OK);
   assign mid = (code >= CODE_OK) && (code < CODE_SERVER);

   always_comb begin
      cur_new = cur_eff;
      case (item_ff.cmd)
         CMD_REPLY: begin
            if ((is_ring || is_ok) && !done_bit) begin
               cur_new.pdd_count = sat_inc(cur_eff.pdd_count, 1'b1);
               cur_new.pdd_total = sat_add(cur_eff.pdd_total, item_ff.elapsed_ms, 1'b1);
            end
            if (is_ok) begin
               cur_new.setup_count = sat_inc(cur_eff.setup_count, 1'b1);
               cur_new.setup_total = sat_add(cur_eff.setup_total, item_ff.elapsed_ms, 1'b1);
               cur_new.answered = sat_inc(cur_eff.answered, 1'b1);
            end
            cur_new.completed = sat_inc(cur_eff.completed,
               mid && (is_ok || code != CODE_TIMEOUT || item_ff.net_reply));
            cur_new.replies = sat_inc(cur_eff.replies, code >= CODE_OK);
         end
         CMD_END: begin
            cur_new.duration_count = sat_inc(cur_eff.duration_count, 1'b1);
            cur_new.duration_total = sat_add(cur_eff.duration_total, item_ff.duration_s, 1'b1);
         end
         default: ;
      endcase
   end

   // ring read address during summing
   assign ring_rd_en = (state_ff == ST_SUM) && (cnt_ff < (WinW+1)'(Window));
   assign ring_raddr = {item_ff.gateway, cnt_ff[WinW-1:0]};

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         gw_rd_ff   <= txn_gw_mem[req.data.txn_slot];
         done_rd_ff <= txn_done_mem[req.data.txn_slot];
         ptr_rd_ff  <= ptr_mem[req.data.gateway];
      end
      cur_rd_ff <= cur_mem[req.ready ? req.data.gateway : g];
      if (ring_rd_en) ring_rd_ff <= ring_mem[ring_raddr];
      if (state_ff == ST_CLEAR) begin
         ring_mem[clr_ff] <= '0;
         txn_done_mem[clr_ff[SlotW-1:0]] <= 1'b0;
         ptr_mem[clr_ff[GwW-1:0]] <= '0;
      end
      if (state_ff == ST_MOD) begin
         case (item_ff.cmd)
            CMD_INVITE: begin
               txn_gw_mem[item_ff.txn_slot] <= item_ff.gateway;
               if (item_ff.first_branch) txn_done_mem[item_ff.txn_slot] <= 1'b0;
            end
            CMD_REPLY: begin
               cur_mem[g] <= cur_new;
               if (is_ring || is_ok) txn_done_mem[item_ff.txn_slot] <= 1'b1;
            end
            CMD_END: cur_mem[g] <= cur_new;
            CMD_TICK: begin
               ring_mem[{item_ff.gateway, ptr_rd_ff}] <= cur_eff;
               ptr_mem[item_ff.gateway] <= ptr_rd_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Gateways; i++) cur_valid_ff[i] <= 1'b0;
      end else if (state_ff == ST_MOD) begin
         case (item_ff.cmd)
            CMD_REPLY, CMD_END: cur_valid_ff[g] <= 1'b1;
            CMD_TICK: cur_valid_ff[g] <= 1'b0;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      clr_in   = clr_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: if (req.valid) begin
            item_in = req.data;
            state_in = ST_READ;
         end
         ST_READ: state_in = ST_MOD;
         ST_MOD: begin
            cnt_in = '0;
            state_in = (item_ff.cmd == CMD_TICK) ? ST_SUM : ST_IDLE;
         end
         ST_SUM: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (WinW+1)'(Window)) state_in = ST_DONE;
         end
         ST_DONE: if (!out_valid_ff || rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         cnt_ff   <= '0;
         sum_add_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cnt_ff   <= cnt_in;
         sum_add_ff <= ring_rd_en;
      end
      item_ff <= item_in;
   end

   csw_ring_sum u_sum (
      .clock (clock),
      .reset (reset),
      .clear (state_ff == ST_MOD),
      .add   (sum_add_ff),
      .entry (ring_rd_ff),
      .sum   (sum)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && (!out_valid_ff || rsp.ready)) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (state_ff == ST_DONE && (!out_valid_ff || rsp.ready)) begin
         out_ff.gateway_out      <= item_ff.gateway;
         out_ff.replies          <= sum.replies;
         out_ff.answered         <= sum.answered;
         out_ff.completed        <= sum.completed;
         out_ff.pdd_count        <= sum.pdd_count;
         out_ff.pdd_total_ms     <= sum.pdd_total;
         out_ff.setup_count      <= sum.setup_count;
         out_ff.setup_total_ms   <= sum.setup_total;
         out_ff.duration_count   <= sum.duration_count;
         out_ff.duration_total_s <= sum.duration_total;
      end
   end
endmodule
`default_nettype wire

/* sim/csw_scoreboard.sv */
// ----------------------------------------------------------------------------
// csw_scoreboard
// Windowed call statistics predictor and result checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package csw_tb_pkg;
   import csw_pkg::*;

   class csw_scoreboard;
      logic [GwW-1:0]  slot_gateway [Transactions];
      bit              slot_pdd_done [Transactions];
      stats_type       live [Gateways];
      stats_type       ring [Gateways][Window];
      int unsigned     ring_head [Gateways];
      rsp_type         pending [$];
      int unsigned     error_count;

      function new();
         foreach (slot_pdd_done[i]) begin
            slot_pdd_done[i] = 0;
            slot_gateway[i] = '0;
         end
         foreach (live[g]) begin
            live[g] = '0;
            ring_head[g] = 0;
            for (int w = 0; w < Window; w++) ring[g][w] = '0;
         end
         error_count = 0;
      endfunction

      static function logic [31:0] bump(logic [31:0] a);
         return (a == Max32) ? a : a + 32'd1;
      endfunction

      static function logic [47:0] accumulate(logic [47:0] a, logic [31:0] b);
         logic [48:0] t;
         t = {1'b0, a} + 49'(b);
         return (t > {1'b0, Max48}) ? Max48 : t[47:0];
      endfunction

      function void note_request(req_type r);
         logic [GwW-1:0] g;
         logic [63:0] c [6];
         logic [63:0] s [3];
         rsp_type o;
         case (r.cmd)
            CMD_INVITE: begin
               slot_gateway[r.txn_slot] = r.gateway;
               if (r.first_branch) slot_pdd_done[r.txn_slot] = 0;
            end
            CMD_REPLY: begin
               g = slot_gateway[r.txn_slot];
               if (r.response_code == CODE_RINGING || r.response_code == CODE_PROGRESS
                   || r.response_code == CODE_OK) begin
                  if (!slot_pdd_done[r.txn_slot]) begin
                     slot_pdd_done[r.txn_slot] = 1;
                     live[g].pdd_count = bump(live[g].pdd_count);
                     live[g].pdd_total = accumulate(live[g].pdd_total, r.elapsed_ms);
                  end
               end
               if (r.response_code == CODE_OK) begin
                  live[g].setup_count = bump(live[g].setup_count);
                  live[g].setup_total = accumulate(live[g].setup_total, r.elapsed_ms);
                  live[g].answered = bump(live[g].answered);
                  live[g].completed = bump(live[g].completed);
               end else if (r.response_code >= CODE_OK && r.response_code < CODE_SERVER
                            && (r.response_code != CODE_TIMEOUT || r.net_reply))
                  live[g].completed = bump(live[g].completed);
               if (r.response_code >= CODE_OK) live[g].replies = bump(live[g].replies);
            end
            CMD_END: begin
               g = r.gateway;
               live[g].duration_count = bump(live[g].duration_count);
               live[g].duration_total = accumulate(live[g].duration_total, r.duration_s);
            end
            default: begin
               g = r.gateway;
               ring[g][ring_head[g]] = live[g];
               live[g] = '0;
               ring_head[g] = (ring_head[g] + 1) % Window;
               foreach (c[k]) c[k] = 0;
               foreach (s[k]) s[k] = 0;
               for (int w = 0; w < Window; w++) begin
                  c[0] += 64'(ring[g][w].replies);
                  c[1] += 64'(ring[g][w].answered);
                  c[2] += 64'(ring[g][w].completed);
                  c[3] += 64'(ring[g][w].pdd_count);
                  c[4] += 64'(ring[g][w].setup_count);
                  c[5] += 64'(ring[g][w].duration_count);
                  s[0] += 64'(ring[g][w].pdd_total);
                  s[1] += 64'(ring[g][w].setup_total);
                  s[2] += 64'(ring[g][w].duration_total);
               end
               foreach (c[k]) if (c[k] > 64'(Max32)) c[k] = 64'(Max32);
               foreach (s[k]) if (s[k] > 64'(Max48)) s[k] = 64'(Max48);
               o.gateway_out = g;
               o.replies = c[0][31:0];
               o.answered = c[1][31:0];
               o.completed = c[2][31:0];
               o.pdd_count = c[3][31:0];
               o.setup_count = c[4][31:0];
               o.duration_count = c[5][31:0];
               o.pdd_total_ms = s[0][47:0];
               o.setup_total_ms = s[1][47:0];
               o.duration_total_s = s[2][47:0];
               pending.push_back(o);
            end
         endcase
      endfunction

      function void check_field(string name, logic [47:0] exp_v, logic [47:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            error_count++;
         end
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("result with no tick outstanding, gateway %0d", a.gateway_out);
            error_count++;
            return;
         end
         e = pending.pop_front();
         check_field("gateway_out", 48'(e.gateway_out), 48'(a.gateway_out));
         check_field("replies", 48'(e.replies), 48'(a.replies));
         check_field("answered", 48'(e.answered), 48'(a.answered));
         check_field("completed", 48'(e.completed), 48'(a.completed));
         check_field("pdd_count", 48'(e.pdd_count), 48'(a.pdd_count));
         check_field("pdd_total_ms", e.pdd_total_ms, a.pdd_total_ms);
         check_field("setup_count", 48'(e.setup_count), 48'(a.setup_count));
         check_field("setup_total_ms", e.setup_total_ms, a.setup_total_ms);
         check_field("duration_count", 48'(e.duration_count), 48'(a.duration_count));
         check_field("duration_total_s", e.duration_total_s, a.duration_total_s);
      endfunction
   endclass
endpackage

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives invite, reply, call-end and tick items with random gaps and
// stalls; every tick result is checked against the scoreboard's windowed
// sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
   import csw_pkg::*;
   import csw_tb_pkg::*;

   localparam int StallLimit = 4000;

   logic clock = 0;
   logic reset = 1;
   csw_req_if req ();
   csw_rsp_if rsp ();
   csw_scoreboard stats = new();
   logic [Transactions-1:0] slot_bound = '0;
   int unsigned idle_cycles = 0;
   bit stim_done = 0;

   call_stats_window_accumulator_top dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   initial forever #5 clock = ~clock;

   initial begin
      req.valid = 0;
      req.data = '0;
      rsp.ready = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) stats.check_result(rsp.data);
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = $urandom_range(0, 5);
         if (stim_done || $urandom_range(0, 3) == 0) n = 0;
         if (n > 0) begin
            rsp.ready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp.ready <= 1;
         @(posedge clock);
      end
   end

   task automatic send(req_type r, bit no_gap = 0);
      int n;
      n = no_gap ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
         req.valid <= 0;
         repeat (n) @(posedge clock);
      end
      req.data <= r;
      req.valid <= 1;
      do @(posedge clock); while (!req.ready);
      stats.note_request(r);
      if (r.cmd == CMD_INVITE) slot_bound[r.txn_slot] = 1;
   endtask

   function automatic req_type noise();
      req_type r;
      r = '0;
      r.txn_slot = 8'($urandom);
      r.first_branch = 1'($urandom);
      r.gateway = 6'($urandom);
      r.response_code = 10'($urandom_range(100, 699));
      r.net_reply = 1'($urandom);
      r.elapsed_ms = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
      r.duration_s = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3600);
      return r;
   endfunction

   function automatic logic [9:0] pick_code();
      case ($urandom_range(0, 9))
         0, 1: return CODE_RINGING;
         2:    return CODE_PROGRESS;
         3, 4: return CODE_OK;
         5:    return CODE_TIMEOUT;
         6:    return 10'($urandom_range(500, 699));
         7:    return 10'($urandom_range(100, 199));
         default: return 10'($urandom_range(201, 499));
      endcase
   endfunction

   task automatic send_call(logic [7:0] slot, logic [5:0] gw);
      req_type r;
      r = noise();
      r.cmd = CMD_INVITE; r.txn_slot = slot; r.gateway = gw; r.first_branch = 1;
      send(r);
      repeat ($urandom_range(1, 3)) begin
         r = noise();
         r.cmd = CMD_REPLY; r.txn_slot = slot; r.response_code = pick_code();
         send(r);
      end
      if ($urandom_range(0, 1)) begin
         r = noise();
         r.cmd = CMD_END; r.gateway = gw;
         send(r);
      end
   endtask

   initial begin
      req_type r;
      int sent;
      logic [5:0] hot_gw;
      @(negedge reset);
      // directed: extremes, each code class, duplicate ringing, later branch
      r = noise(); r.cmd = CMD_INVITE; r.txn_slot = 8'hFF; r.gateway = 6'h3F;
      r.first_branch = 1; send(r);
      r = noise(); r.cmd = CMD_INVITE; r.txn_slot = 0; r.gateway = 0;
      r.first_branch = 1; send(r);
      r = noise(); r.cmd = CMD_REPLY; r.txn_slot = 8'hFF; r.response_code = CODE_RINGING;
      r.elapsed_ms = 32'hFFFF_FFFF; send(r);
      r.response_code = CODE_PROGRESS; r.elapsed_ms = 7; send(r);
      r.response_code = CODE_OK; r.elapsed_ms = 32'hFFFF_FFFF; send(r);
      r = noise(); r.cmd = CMD_REPLY; r.txn_slot = 0; r.response_code = CODE_OK;
      r.elapsed_ms = 0; send(r);
      r.response_code = CODE_TIMEOUT; r.net_reply = 0; send(r);
      r.response_code = CODE_TIMEOUT; r.net_reply = 1; send(r);
      r.response_code = 10'd699; send(r);
      r.response_code = 10'd100; send(r);
      r.response_code = 10'd486; send(r);
      r = noise(); r.cmd = CMD_INVITE; r.txn_slot = 0; r.gateway = 0;
      r.first_branch = 0; send(r);
      r = noise(); r.cmd = CMD_REPLY; r.txn_slot = 0; r.response_code = CODE_RINGING;
      send(r);
      r = noise(); r.cmd = CMD_END; r.gateway = 6'h3F; r.duration_s = 32'hFFFF_FFFF;
      send(r); send(r);
      r.duration_s = 0; r.gateway = 0; send(r);
      r = noise(); r.cmd = CMD_TICK; r.gateway = 6'h3F; send(r);
      r.gateway = 0; send(r);
      req.valid <= 0;
      while (stats.pending.size() != 0) @(posedge clock);
      // large sums: maximal durations accumulated over more than the whole window
      hot_gw = 6'h2A;
      repeat (Window + 1) begin
         repeat (3) begin
            r = noise(); r.cmd = CMD_END; r.gateway = hot_gw;
            r.duration_s = 32'hFFFF_FFFF; send(r, 1);
         end
         r = noise(); r.cmd = CMD_TICK; r.gateway = hot_gw; send(r, 1);
      end
      sent = 0;
      while (sent < 550) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               send_call(8'($urandom), 6'($urandom_range(0, 7)));
               sent += 4;
            end
            5, 6: begin
               r = noise();
               r.cmd = CMD_TICK;
               if ($urandom_range(0, 2) != 0) r.gateway = 6'($urandom_range(0, 7));
               send(r);
               sent++;
            end
            7: begin
               r = noise(); r.cmd = CMD_END; send(r); sent++;
            end
            default: begin
               r = noise();
               r.cmd = $urandom_range(0, 1) ? CMD_INVITE : CMD_REPLY;
               if (r.cmd == CMD_REPLY && !slot_bound[r.txn_slot]) r.cmd = CMD_INVITE;
               send(r);
               sent++;
            end
         endcase
      end
      req.valid <= 0;
      stim_done = 1;
      while (stats.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (stats.error_count == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
